>>> hdl/fpj_pkg.sv
// Package for the five-point Jacobi sweep: fixed widths, register indexes,
// reset values, the command flag struct and the back-end sequencer states.
// No dependencies; used by every module of the block except fpj_fifo.
`default_nettype none

package fpj_pkg;

    // configuration port
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int GRID_SIZE_W = 6;
    localparam int OMEGA_W     = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OMEGA     = 2'd2;

    localparam logic [GRID_SIZE_W-1:0] GRID_SIZE_RST = 6'd32;
    localparam logic                   MODE_RST      = 1'b0;
    localparam logic [OMEGA_W-1:0]     OMEGA_RST     = 16'd21823;

    // mode codes
    localparam logic MODE_SMOOTH   = 1'b0;
    localparam logic MODE_RESIDUAL = 1'b1;

    // result index width and fixed-point shift of the omega product
    localparam int IDX_OUT_W  = 5;
    localparam int FRAC_SHIFT = 17;
    // headroom of the stencil sum over one value
    localparam int SUM_GUARD  = 4;

    // classification of one accepted point
    typedef struct packed {
        logic has_result;   // row above exists, a result is due
        logic last_point;   // final point of the grid, flush follows
        logic upper_valid;  // row two above exists
    } t_cmd_flags;

    // back-end sequencer
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD0,
        ST_RD1,
        ST_RD2,
        ST_SUM,
        ST_MUL,
        ST_OUT
    } t_back_state;

endpackage

`default_nettype wire

>>> hdl/fpj_fifo.sv
// Small first-word-fall-through queue built from registers.
// Used between front and back, and on the result side. Needs no package.
`default_nettype none

module fpj_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic      [WIDTH-1:0] o_data,
    output logic                  o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_do_push, w_do_pop;

    assign o_full    = (r_count == CNT_W'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;
    assign o_data    = r_mem[r_rd_ptr];

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (w_do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (w_do_push && !w_do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (!w_do_push && w_do_pop) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

>>> hdl/fpj_front.sv
// Front end: accepts grid points, tracks row and column, classifies each beat.
// Depends on fpj_pkg (t_cmd_flags).
`default_nettype none

module fpj_front #(
    parameter int GRID_MAX    = 32,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_restart,
    input  wire logic [$clog2(GRID_MAX+1)-1:0]   i_size,
    input  wire logic                            i_push,
    input  wire logic signed [VALUE_WIDTH-1:0]   i_x,
    input  wire logic signed [VALUE_WIDTH-1:0]   i_b,
    input  wire logic                            i_q_full,
    output logic                                 o_full,
    output logic                                 o_q_push,
    output fpj_pkg::t_cmd_flags                  o_flags,
    output logic [$clog2(GRID_MAX)-1:0]          o_row,
    output logic [$clog2(GRID_MAX)-1:0]          o_col,
    output logic signed [VALUE_WIDTH-1:0]        o_x,
    output logic signed [VALUE_WIDTH-1:0]        o_b
);

    localparam int CW = $clog2(GRID_MAX);
    localparam int NW = $clog2(GRID_MAX + 1);

    logic [CW-1:0] r_row, r_col;
    logic          w_accept, w_col_end, w_row_end;

    assign o_full    = i_q_full;
    assign w_accept  = i_push && !i_q_full;
    assign w_col_end = (NW'(r_col) == i_size - NW'(1));
    assign w_row_end = (NW'(r_row) == i_size - NW'(1));

    // position of the next arriving point
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else if (i_restart) begin
            r_row <= '0;
            r_col <= '0;
        end else if (w_accept) begin
            if (w_col_end) begin
                r_col <= '0;
                r_row <= w_row_end ? '0 : r_row + CW'(1);
            end else begin
                r_col <= r_col + CW'(1);
            end
        end
    end

    // classify the beat for the back end
    always_comb begin
        o_q_push            = w_accept;
        o_flags.has_result  = (r_row != '0);
        o_flags.last_point  = w_row_end && w_col_end;
        o_flags.upper_valid = (NW'(r_row) >= NW'(2));
        o_row               = r_row;
        o_col               = r_col;
        o_x                 = i_x;
        o_b                 = i_b;
    end

endmodule

`default_nettype wire

>>> hdl/fpj_back.sv
// Back end: line memories, stencil sum, omega product, rounding, saturation,
// and the flush of the last row. Depends on fpj_pkg.
`default_nettype none

module fpj_back #(
    parameter int GRID_MAX    = 32,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic [$clog2(GRID_MAX+1)-1:0]      i_size,
    input  wire logic                               i_mode,
    input  wire logic [fpj_pkg::OMEGA_W-1:0]        i_omega,
    input  wire logic                               i_cmd_empty,
    output logic                                    o_cmd_pop,
    input  wire fpj_pkg::t_cmd_flags                i_flags,
    input  wire logic [$clog2(GRID_MAX)-1:0]        i_row,
    input  wire logic [$clog2(GRID_MAX)-1:0]        i_col,
    input  wire logic signed [VALUE_WIDTH-1:0]      i_x,
    input  wire logic signed [VALUE_WIDTH-1:0]      i_b,
    input  wire logic                               i_out_full,
    output logic                                    o_out_push,
    output logic signed [VALUE_WIDTH-1:0]           o_out_value,
    output logic [fpj_pkg::IDX_OUT_W-1:0]           o_out_row,
    output logic [fpj_pkg::IDX_OUT_W-1:0]           o_out_col,
    output logic                                    o_out_last
);

    localparam int CW = $clog2(GRID_MAX);
    localparam int NW = $clog2(GRID_MAX + 1);
    localparam int AW = $clog2(2 * GRID_MAX);
    localparam int VW = VALUE_WIDTH;
    localparam int DW = VALUE_WIDTH + fpj_pkg::SUM_GUARD;
    localparam int PW = DW + fpj_pkg::FRAC_SHIFT;
    localparam int RW = DW + 1;
    localparam logic signed [PW-1:0] ROUND_HALF = PW'(1) <<< (fpj_pkg::FRAC_SHIFT - 1);

    // line address: row parity selects the half
    function automatic logic [AW-1:0] xaddr(input logic par, input logic [CW-1:0] col);
        logic [AW-1:0] base;
        base = par ? AW'(GRID_MAX) : '0;
        return base + AW'(col);
    endfunction

    // clamp to the signed result range
    function automatic logic signed [VW-1:0] sat(input logic signed [RW-1:0] v);
        logic [RW-VW:0] hi;
        hi = v[RW-1:VW-1];
        if (hi == '0 || hi == '1) begin
            return v[VW-1:0];
        end else if (v[RW-1]) begin
            return {1'b1, {(VW-1){1'b0}}};
        end else begin
            return {1'b0, {(VW-1){1'b1}}};
        end
    endfunction

    fpj_pkg::t_back_state r_state, n_state;

    logic signed [VW-1:0] r_x_mem [2*GRID_MAX];
    logic signed [VW-1:0] r_b_mem [GRID_MAX];
    logic signed [VW-1:0] r_rd_a, r_rd_b, r_b_rd;

    logic                 r_flush, r_final, r_has, r_u_ok, r_c_par;
    logic [CW-1:0]        r_row, r_col;
    logic signed [VW-1:0] r_x_in, r_b_in;
    logic signed [VW-1:0] r_c, r_l, r_r, r_u, r_bv;
    logic signed [DW-1:0] r_d;
    logic signed [PW-1:0] r_prod;

    logic [AW-1:0]        w_addr_a, w_addr_b, w_wr_addr;
    logic                 w_we;
    logic [CW-1:0]        w_col_l, w_col_r;
    logic                 w_col_first, w_col_last;
    logic signed [DW-1:0] w_dn, w_d;
    logic signed [16:0]   w_om;
    logic signed [PW-1:0] w_prod, w_round;
    logic signed [DW-1:0] w_q;
    logic signed [RW-1:0] w_upd;

    assign w_col_first = (r_col == '0);
    assign w_col_last  = (NW'(r_col) == i_size - NW'(1));
    assign w_col_l     = w_col_first ? r_col : r_col - CW'(1);
    assign w_col_r     = w_col_last ? r_col : r_col + CW'(1);
    assign w_wr_addr   = xaddr(~r_c_par, r_col);

    // stencil sum: b - 4C + L + R + U + D
    assign w_dn = r_flush ? DW'(0) : DW'(r_x_in);
    assign w_d  = DW'(r_bv) - (DW'(r_c) <<< 2) + DW'(r_l) + DW'(r_r) + DW'(r_u) + w_dn;

    // weighted update C + omega*d/2^17, rounded half up
    assign w_om    = signed'({1'b0, i_omega});
    assign w_prod  = PW'(w_om) * PW'(r_d);
    assign w_round = r_prod + ROUND_HALF;
    assign w_q     = w_round[PW-1:fpj_pkg::FRAC_SHIFT];
    assign w_upd   = RW'(r_c) + RW'(w_q);

    // result beat
    always_comb begin
        if (i_mode == fpj_pkg::MODE_RESIDUAL) begin
            o_out_value = sat(RW'(r_d));
        end else begin
            o_out_value = sat(w_upd);
        end
        o_out_row  = fpj_pkg::IDX_OUT_W'(r_row);
        o_out_col  = fpj_pkg::IDX_OUT_W'(r_col);
        o_out_last = r_flush && w_col_last;
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fpj_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state, memory ports and handshakes
    always_comb begin
        n_state    = r_state;
        o_cmd_pop  = 1'b0;
        o_out_push = 1'b0;
        w_we       = 1'b0;
        w_addr_a   = xaddr(r_c_par, r_col);
        w_addr_b   = xaddr(r_c_par, w_col_l);
        unique case (r_state)
            fpj_pkg::ST_IDLE: begin
                if (!i_cmd_empty) begin
                    o_cmd_pop = 1'b1;
                    n_state   = i_flags.has_result ? fpj_pkg::ST_RD0 : fpj_pkg::ST_SUM;
                end
            end
            fpj_pkg::ST_RD0: begin
                n_state = fpj_pkg::ST_RD1;
            end
            fpj_pkg::ST_RD1: begin
                w_addr_a = xaddr(r_c_par, w_col_r);
                w_addr_b = xaddr(~r_c_par, r_col);
                n_state  = fpj_pkg::ST_RD2;
            end
            fpj_pkg::ST_RD2: begin
                n_state = fpj_pkg::ST_SUM;
            end
            fpj_pkg::ST_SUM: begin
                w_we    = !r_flush;
                n_state = r_has ? fpj_pkg::ST_MUL : fpj_pkg::ST_IDLE;
            end
            fpj_pkg::ST_MUL: begin
                n_state = fpj_pkg::ST_OUT;
            end
            fpj_pkg::ST_OUT: begin
                if (!i_out_full) begin
                    o_out_push = 1'b1;
                    if (r_flush) begin
                        n_state = w_col_last ? fpj_pkg::ST_IDLE : fpj_pkg::ST_RD0;
                    end else begin
                        n_state = r_final ? fpj_pkg::ST_RD0 : fpj_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = fpj_pkg::ST_IDLE;
            end
        endcase
    end

    // line memories: one write, registered reads
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_x_mem[w_wr_addr] <= r_x_in;
            r_b_mem[r_col]     <= r_b_in;
        end
        r_rd_a <= r_x_mem[w_addr_a];
        r_rd_b <= r_x_mem[w_addr_b];
        r_b_rd <= r_b_mem[r_col];
    end

    // flush control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flush <= 1'b0;
        end else if (r_state == fpj_pkg::ST_IDLE && o_cmd_pop) begin
            r_flush <= 1'b0;
        end else if (o_out_push && !r_flush && r_final) begin
            r_flush <= 1'b1;
        end
    end

    // job and operand registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            fpj_pkg::ST_IDLE: begin
                if (o_cmd_pop) begin
                    r_col   <= i_col;
                    r_row   <= i_row - CW'(1);
                    r_c_par <= ~i_row[0];
                    r_u_ok  <= i_flags.upper_valid;
                    r_has   <= i_flags.has_result;
                    r_final <= i_flags.last_point;
                    r_x_in  <= i_x;
                    r_b_in  <= i_b;
                end
            end
            fpj_pkg::ST_RD1: begin
                r_c  <= r_rd_a;
                r_l  <= w_col_first ? '0 : r_rd_b;
                r_bv <= r_b_rd;
            end
            fpj_pkg::ST_RD2: begin
                r_r <= w_col_last ? '0 : r_rd_a;
                r_u <= r_u_ok ? r_rd_b : '0;
            end
            fpj_pkg::ST_SUM: begin
                r_d <= w_d;
            end
            fpj_pkg::ST_MUL: begin
                r_prod <= w_prod;
            end
            fpj_pkg::ST_OUT: begin
                if (o_out_push) begin
                    if (r_flush) begin
                        r_col <= r_col + CW'(1);
                    end else if (r_final) begin
                        // switch to the last row, its upper row is complete
                        r_col   <= '0;
                        r_row   <= r_row + CW'(1);
                        r_c_par <= ~r_c_par;
                        r_u_ok  <= 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

>>> hdl/five_point_jacobi_sweep.sv
// Five-point weighted Jacobi / residual stencil, streamed row-major.
// Channels: input queue (push/full) takes one grid point a beat, x and b in
// signed Q16.16. Result queue (empty/pop) gives out_value with row, col and
// last. Config port: i_cfg_we, i_cfg_idx (0 grid size, 1 mode, 2 omega),
// i_cfg_data; a grid size write restarts the grid at point zero.
// Each point of row i >= 1 yields the result for the point above it; the
// final point also yields the whole last row, the last beat with last = 1.
// Timing: a point of row 0 holds the back end for its pop and sum steps, any
// other point for pop, three line-memory read steps on the two-port x memory,
// sum, multiply and output; the final point adds read, sum, multiply and
// output steps for each column of the last row.
// Reset: config to defaults (32, smooth, omega 21823), position and queues
// cleared; line memories are not cleared and hold no valid data.
// When the receiver stalls the 4-entry result queue fills, the back end
// waits at its output step, the 2-entry command queue fills and full rises.
// Depends on fpj_pkg, fpj_fifo, fpj_front, fpj_back.
`default_nettype none

module five_point_jacobi_sweep #(
    parameter int GRID_MAX    = 32,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_cfg_we,
    input  wire logic [fpj_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  wire logic [fpj_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    input  wire logic                                  push,
    output logic                                       full,
    input  wire logic signed [VALUE_WIDTH-1:0]         i_x_value,
    input  wire logic signed [VALUE_WIDTH-1:0]         i_b_value,
    output logic                                       empty,
    input  wire logic                                  pop,
    output logic signed [VALUE_WIDTH-1:0]              o_out_value,
    output logic [fpj_pkg::IDX_OUT_W-1:0]              o_row,
    output logic [fpj_pkg::IDX_OUT_W-1:0]              o_col,
    output logic                                       o_last
);

    localparam int CW    = $clog2(GRID_MAX);
    localparam int NW    = $clog2(GRID_MAX + 1);
    localparam int VW    = VALUE_WIDTH;
    localparam int FLG_W = $bits(fpj_pkg::t_cmd_flags);
    localparam int CMD_W = FLG_W + 2 * CW + 2 * VW;
    localparam int RES_W = VW + 2 * fpj_pkg::IDX_OUT_W + 1;

    // configuration registers
    logic [fpj_pkg::GRID_SIZE_W-1:0] r_grid_size;
    logic                            r_mode;
    logic [fpj_pkg::OMEGA_W-1:0]     r_omega;
    logic [NW-1:0]                   w_size;
    logic                            w_restart;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_size <= fpj_pkg::GRID_SIZE_RST;
            r_mode      <= fpj_pkg::MODE_RST;
            r_omega     <= fpj_pkg::OMEGA_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                fpj_pkg::CFG_GRID_SIZE: r_grid_size <= i_cfg_data[fpj_pkg::GRID_SIZE_W-1:0];
                fpj_pkg::CFG_MODE:      r_mode      <= i_cfg_data[0];
                fpj_pkg::CFG_OMEGA:     r_omega     <= i_cfg_data[fpj_pkg::OMEGA_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign w_restart = i_cfg_we && (i_cfg_idx == fpj_pkg::CFG_GRID_SIZE);

    // effective grid size: small values act as 2, large as GRID_MAX
    always_comb begin
        if (r_grid_size < fpj_pkg::GRID_SIZE_W'(2)) begin
            w_size = NW'(2);
        end else if (r_grid_size > fpj_pkg::GRID_SIZE_W'(GRID_MAX)) begin
            w_size = NW'(GRID_MAX);
        end else begin
            w_size = NW'(r_grid_size);
        end
    end

    // front end
    logic                   w_cmd_full, w_cmd_push;
    fpj_pkg::t_cmd_flags    w_f_flags;
    logic [CW-1:0]          w_f_row, w_f_col;
    logic signed [VW-1:0]   w_f_x, w_f_b;

    fpj_front #(
        .GRID_MAX    (GRID_MAX),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_restart (w_restart),
        .i_size    (w_size),
        .i_push    (push),
        .i_x       (i_x_value),
        .i_b       (i_b_value),
        .i_q_full  (w_cmd_full),
        .o_full    (full),
        .o_q_push  (w_cmd_push),
        .o_flags   (w_f_flags),
        .o_row     (w_f_row),
        .o_col     (w_f_col),
        .o_x       (w_f_x),
        .o_b       (w_f_b)
    );

    // command queue between front and back
    logic [CMD_W-1:0]       w_cmd_wr, w_cmd_rd;
    logic                   w_cmd_empty, w_cmd_pop;
    fpj_pkg::t_cmd_flags    w_q_flags;
    logic [CW-1:0]          w_q_row, w_q_col;
    logic signed [VW-1:0]   w_q_x, w_q_b;

    assign w_cmd_wr = {w_f_flags, w_f_row, w_f_col, w_f_x, w_f_b};
    assign {w_q_flags, w_q_row, w_q_col, w_q_x, w_q_b} = w_cmd_rd;

    fpj_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (2)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_cmd_push),
        .i_data  (w_cmd_wr),
        .o_full  (w_cmd_full),
        .i_pop   (w_cmd_pop),
        .o_data  (w_cmd_rd),
        .o_empty (w_cmd_empty)
    );

    // back end
    logic                               w_res_full, w_res_push;
    logic signed [VW-1:0]               w_b_value;
    logic [fpj_pkg::IDX_OUT_W-1:0]      w_b_row, w_b_col;
    logic                               w_b_last;

    fpj_back #(
        .GRID_MAX    (GRID_MAX),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_size      (w_size),
        .i_mode      (r_mode),
        .i_omega     (r_omega),
        .i_cmd_empty (w_cmd_empty),
        .o_cmd_pop   (w_cmd_pop),
        .i_flags     (w_q_flags),
        .i_row       (w_q_row),
        .i_col       (w_q_col),
        .i_x         (w_q_x),
        .i_b         (w_q_b),
        .i_out_full  (w_res_full),
        .o_out_push  (w_res_push),
        .o_out_value (w_b_value),
        .o_out_row   (w_b_row),
        .o_out_col   (w_b_col),
        .o_out_last  (w_b_last)
    );

    // result queue
    logic [RES_W-1:0] w_res_wr, w_res_rd;

    assign w_res_wr = {w_b_value, w_b_row, w_b_col, w_b_last};
    assign {o_out_value, o_row, o_col, o_last} = w_res_rd;

    fpj_fifo #(
        .WIDTH (RES_W),
        .DEPTH (4)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res_wr),
        .o_full  (w_res_full),
        .i_pop   (pop),
        .o_data  (w_res_rd),
        .o_empty (empty)
    );

    // checks
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_push |-> !w_res_full)
        else $error("result beat pushed into a full queue");

    a_last_diag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_last) |-> (o_row == o_col))
        else $error("last beat not on the final grid point");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queues not empty after reset");

endmodule

`default_nettype wire
